[hdl/cidbt_pkg.sv]
`timescale 1ns / 1ps

package cidbt_pkg;

    localparam int ID_WIDTH = 29;
    localparam int LEN_WIDTH = 4;
    localparam int PAYLOAD_WIDTH = 64;
    localparam int PAYLOAD_BYTES = 8;

    typedef logic [ID_WIDTH-1:0]      t_id;
    typedef logic [LEN_WIDTH-1:0]     t_len;
    typedef logic [PAYLOAD_WIDTH-1:0] t_payload;

    localparam t_len MAX_LEN = t_len'(PAYLOAD_BYTES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_DONE
    } t_state;

    // mask of the leading n bytes, byte 0 in the top bits
    function automatic t_payload byte_span(input t_len n);
        t_payload m;
        m = '0;
        for (int b = 0; b < PAYLOAD_BYTES; b++) begin
            if (t_len'(b) < n) begin
                m[PAYLOAD_WIDTH-1-8*b -: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    function automatic t_len min_len(input t_len a, input t_len b);
        return (a < b) ? a : b;
    endfunction

endpackage

[hdl/can_id_bit_change_tracker.sv]
`timescale 1ns / 1ps

// CAN identifier bit-change tracker.
// Input channel: i_valid / o_stall carries one frame per transaction
// (identifier, byte count, payload). Output channel: o_valid / i_stall
// carries one result per frame: echoed identifier, seen-before flag,
// bits changed since that identifier's last frame, the sticky variance
// mask and a table-full flag.
// A frame is taken only while the block is idle. The identifier table is
// searched one entry per cycle through a single registered read port, each
// entry being compared while the next is read; a hit, or a miss once the
// fill count is reached, moves to S_UPDATE, which writes the table, and then
// S_DONE loads the output register. No new frame is taken before S_DONE.
// Reset clears the fill count but no table entry; entries are filled in order,
// so the count alone marks which entries are valid and no clearing pass is run.
// A result waits in the output register while the receiver stalls; the
// next frame may be accepted and searched meanwhile, and its result then
// waits in the sequencer until the output register is free.
module can_id_bit_change_tracker #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  cidbt_pkg::t_id      i_frame_identifier,
    input  cidbt_pkg::t_len     i_byte_count,
    input  cidbt_pkg::t_payload i_data_bytes,
    output logic                o_valid,
    input  logic                i_stall,
    output cidbt_pkg::t_id      o_echo_identifier,
    output logic                o_seen_before,
    output cidbt_pkg::t_payload o_change_mask,
    output cidbt_pkg::t_payload o_variance_mask,
    output logic                o_table_full
);

    import cidbt_pkg::*;

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] DEPTH = CW'(TABLE_ENTRIES);

    // table memories
    t_id      id_mem     [TABLE_ENTRIES];
    t_payload first_mem  [TABLE_ENTRIES];
    t_len     flen_mem   [TABLE_ENTRIES];
    t_payload last_mem   [TABLE_ENTRIES];
    t_len     llen_mem   [TABLE_ENTRIES];
    t_payload sticky_mem [TABLE_ENTRIES];

    t_state          r_state, n_state;
    logic [CW-1:0]   r_used, n_used;
    logic [CW-1:0]   r_idx, n_idx;
    logic [AW-1:0]   r_prev_idx, n_prev_idx;
    logic            r_prev_v, n_prev_v;
    logic            r_hit, n_hit;
    logic            r_out_valid, n_out_valid;

    t_id             r_id;
    t_len            r_len;
    t_payload        r_data;

    t_id             r_rd_id;
    t_payload        r_rd_first;
    t_len            r_rd_flen;
    t_payload        r_rd_last;
    t_len            r_rd_llen;
    t_payload        r_rd_sticky;

    logic            r_p_seen, n_p_seen;
    t_payload        r_p_chg, n_p_chg;
    t_payload        r_p_var, n_p_var;
    logic            r_p_full, n_p_full;

    t_id             r_o_id;
    logic            r_o_seen;
    t_payload        r_o_chg;
    t_payload        r_o_var;
    logic            r_o_full;

    logic            w_accept;
    logic            w_match;
    logic            w_rd_en;
    logic            w_hit_we;
    logic            w_new_we;
    logic            w_out_load;
    t_len            w_len;
    t_payload        w_chg;
    t_payload        w_sticky;

    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && (r_state == S_IDLE);
    assign w_len    = (i_byte_count > MAX_LEN) ? MAX_LEN : i_byte_count;
    assign w_match  = r_prev_v && (r_rd_id == r_id);

    assign w_chg    = (r_data ^ r_rd_last) & byte_span(min_len(r_len, r_rd_llen));
    assign w_sticky = r_rd_sticky
                    | ((r_data ^ r_rd_first) & byte_span(min_len(r_len, r_rd_flen)));

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_idx       = r_idx;
        n_prev_idx  = r_prev_idx;
        n_prev_v    = r_prev_v;
        n_hit       = r_hit;
        n_out_valid = r_out_valid;
        n_p_seen    = r_p_seen;
        n_p_chg     = r_p_chg;
        n_p_var     = r_p_var;
        n_p_full    = r_p_full;
        w_rd_en     = 1'b0;
        w_hit_we    = 1'b0;
        w_new_we    = 1'b0;
        w_out_load  = 1'b0;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_idx    = '0;
                    n_prev_v = 1'b0;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                // compare the entry read last cycle while reading the next one
                if (w_match) begin
                    n_hit   = 1'b1;
                    n_state = S_UPDATE;
                end else if (r_idx < r_used) begin
                    w_rd_en    = 1'b1;
                    n_prev_idx = r_idx[AW-1:0];
                    n_prev_v   = 1'b1;
                    n_idx      = r_idx + CW'(1);
                end else begin
                    n_hit   = 1'b0;
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                n_p_seen = r_hit;
                n_p_chg  = '0;
                n_p_var  = '0;
                n_p_full = 1'b0;
                if (r_hit) begin
                    w_hit_we = 1'b1;
                    n_p_chg  = w_chg;
                    n_p_var  = w_sticky;
                end else if (r_used < DEPTH) begin
                    w_new_we = 1'b1;
                    n_used   = r_used + CW'(1);
                end else begin
                    n_p_full = 1'b1;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    w_out_load  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
            r_prev_v    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
            r_prev_v    <= n_prev_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_prev_idx <= n_prev_idx;
        r_hit      <= n_hit;
        r_p_seen   <= n_p_seen;
        r_p_chg    <= n_p_chg;
        r_p_var    <= n_p_var;
        r_p_full   <= n_p_full;
        if (w_accept) begin
            r_id   <= i_frame_identifier;
            r_len  <= w_len;
            r_data <= i_data_bytes & byte_span(w_len);
        end
        if (w_out_load) begin
            r_o_id   <= r_id;
            r_o_seen <= r_p_seen;
            r_o_chg  <= r_p_chg;
            r_o_var  <= r_p_var;
            r_o_full <= r_p_full;
        end
    end

    // single port table: one registered read or one write per cycle
    always_ff @(posedge i_clk) begin
        if (w_new_we) begin
            id_mem[r_used[AW-1:0]]     <= r_id;
            first_mem[r_used[AW-1:0]]  <= r_data;
            flen_mem[r_used[AW-1:0]]   <= r_len;
            last_mem[r_used[AW-1:0]]   <= r_data;
            llen_mem[r_used[AW-1:0]]   <= r_len;
            sticky_mem[r_used[AW-1:0]] <= '0;
        end
        if (w_hit_we) begin
            last_mem[r_prev_idx]   <= r_data;
            llen_mem[r_prev_idx]   <= r_len;
            sticky_mem[r_prev_idx] <= w_sticky;
        end
        if (w_rd_en) begin
            r_rd_id     <= id_mem[r_idx[AW-1:0]];
            r_rd_first  <= first_mem[r_idx[AW-1:0]];
            r_rd_flen   <= flen_mem[r_idx[AW-1:0]];
            r_rd_last   <= last_mem[r_idx[AW-1:0]];
            r_rd_llen   <= llen_mem[r_idx[AW-1:0]];
            r_rd_sticky <= sticky_mem[r_idx[AW-1:0]];
        end
    end

    assign o_valid           = r_out_valid;
    assign o_echo_identifier = r_o_id;
    assign o_seen_before     = r_o_seen;
    assign o_change_mask     = r_o_chg;
    assign o_variance_mask   = r_o_var;
    assign o_table_full      = r_o_full;

endmodule
